>>> rtl/core/mga_pkg.sv
// Shared types and constants of the masked Gaussian RGB average block.
// Used by every module and interface under rtl/core; depends on nothing.

package mga_pkg;

    localparam int WINDOW_WIDTH  = 3;
    localparam int WINDOW_HEIGHT = 3;
    localparam int WINDOW_PIXELS = WINDOW_WIDTH * WINDOW_HEIGHT;
    localparam int POS_W         = (WINDOW_PIXELS > 1) ? $clog2(WINDOW_PIXELS) : 1;

    localparam int CH_W     = 8;
    localparam int W_W      = 4;
    localparam int MASK_W   = 36;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 8;
    localparam int NUM_CH   = 3;
    localparam int DIV_ITER = SUM_W - CH_W;
    localparam int ITER_W   = $clog2(DIV_ITER);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [MASK_W-1:0] RESET_MASK = 36'h121242121;

    // Channel lanes of the sums and the divider.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [W_W-1:0]  weight;
        logic            count_en;
        logic            last;
    } t_pix_entry;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]             count;
    } t_div_req;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            no_weight;
        logic            clipped;
    } t_result;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

>>> rtl/core/mga_pix_if.sv
// Pixel channel: valid/ready handshake carrying one RGB window pixel.
// Depends on mga_pkg for the channel width.

interface mga_pix_if;
    logic                    valid;
    logic                    ready;
    logic [mga_pkg::CH_W-1:0] red;
    logic [mga_pkg::CH_W-1:0] green;
    logic [mga_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/core/mga_res_if.sv
// Result channel: valid/ready handshake carrying one averaged window result.
// Depends on mga_pkg for the channel width.

interface mga_res_if;
    logic                    valid;
    logic                    ready;
    logic [mga_pkg::CH_W-1:0] red_out;
    logic [mga_pkg::CH_W-1:0] green_out;
    logic [mga_pkg::CH_W-1:0] blue_out;
    logic                    no_weight;
    logic                    clipped;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output no_weight, output clipped, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input no_weight, input clipped, output ready);
endinterface

>>> rtl/core/mga_front.sv
// Front end: holds the mask register and the window position, tags each pixel
// with its weight, count enable and end-of-window mark. Depends on mga_pkg, mga_pix_if.

module mga_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mga_pkg::MASK_W-1:0]   i_cfg_data,
    mga_pix_if.sink                      i_pix,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output mga_pkg::t_pix_entry          o_q_entry
);

    logic [mga_pkg::MASK_W-1:0] r_mask;
    logic [mga_pkg::POS_W-1:0]  r_pos;
    logic [mga_pkg::POS_W-1:0]  n_pos;
    logic                       last_pos;

    assign last_pos = (r_pos == mga_pkg::POS_W'(mga_pkg::WINDOW_PIXELS - 1));
    assign n_pos    = last_pos ? '0 : r_pos + 1'b1;

    assign i_pix.ready = !i_q_full;
    assign o_q_push    = i_pix.valid && !i_q_full;

    always_comb begin
        o_q_entry.red      = i_pix.red;
        o_q_entry.green    = i_pix.green;
        o_q_entry.blue     = i_pix.blue;
        o_q_entry.weight   = r_mask[mga_pkg::W_W * r_pos +: mga_pkg::W_W];
        o_q_entry.count_en = (|i_pix.red) && (|i_pix.green) && (|i_pix.blue);
        o_q_entry.last     = last_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= mga_pkg::RESET_MASK;
            r_pos  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            if (o_q_push) begin
                r_pos <= n_pos;
            end
        end
    end

endmodule

>>> rtl/core/mga_fifo.sv
// Short queue of tagged pixels between the front end and the back end.
// Depends on mga_pkg for the entry type and depth.

module mga_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mga_pkg::t_pix_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output mga_pkg::t_pix_entry o_entry,
    output logic                o_empty
);

    mga_pkg::t_pix_entry           r_mem [mga_pkg::QUEUE_DEPTH];
    logic [mga_pkg::QUEUE_AW-1:0]  r_wr;
    logic [mga_pkg::QUEUE_AW-1:0]  r_rd;
    logic [mga_pkg::QUEUE_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (mga_pkg::QUEUE_AW + 1)'(mga_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> rtl/core/mga_div.sv
// Three-lane restoring divider with saturation, one quotient bit per lane per cycle.
// Holds its result until it is taken. Depends on mga_pkg.

module mga_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mga_pkg::t_div_req i_req,
    output logic              o_idle,
    output logic              o_valid,
    input  logic              i_ready,
    output mga_pkg::t_result  o_result
);

    mga_pkg::t_div_state r_state;
    mga_pkg::t_div_state n_state;

    logic [mga_pkg::ITER_W-1:0] r_bit;
    logic [mga_pkg::CNT_W-1:0]  r_count;
    logic                       r_no_wt;
    logic [mga_pkg::NUM_CH-1:0] r_clip;
    logic [mga_pkg::CH_W-1:0]   r_quo [mga_pkg::NUM_CH];
    logic [mga_pkg::CNT_W-1:0]  r_rem [mga_pkg::NUM_CH];

    logic [mga_pkg::CNT_W:0]    trial [mga_pkg::NUM_CH];
    logic [mga_pkg::CNT_W:0]    diff  [mga_pkg::NUM_CH];
    logic [mga_pkg::NUM_CH-1:0] fits;
    logic [mga_pkg::CH_W-1:0]   lane_out [mga_pkg::NUM_CH];
    logic                       load;

    assign load = i_start && (r_state == mga_pkg::DIV_IDLE);

    always_comb begin
        n_state = r_state;
        o_idle  = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            mga_pkg::DIV_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = (i_req.count == '0) ? mga_pkg::DIV_DONE : mga_pkg::DIV_RUN;
                end
            end
            mga_pkg::DIV_RUN: begin
                if (r_bit == mga_pkg::ITER_W'(mga_pkg::DIV_ITER - 1)) begin
                    n_state = mga_pkg::DIV_DONE;
                end
            end
            mga_pkg::DIV_DONE: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = mga_pkg::DIV_IDLE;
                end
            end
            default: n_state = mga_pkg::DIV_IDLE;
        endcase
    end

    // Each lane shifts the next dividend bit into its partial remainder.
    always_comb begin
        for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
            trial[ch] = {r_rem[ch], r_quo[ch][mga_pkg::CH_W-1]};
            fits[ch]  = (trial[ch] >= {1'b0, r_count});
            diff[ch]  = trial[ch] - {1'b0, r_count};
            if (r_no_wt) begin
                lane_out[ch] = '0;
            end else if (r_clip[ch]) begin
                lane_out[ch] = '1;
            end else begin
                lane_out[ch] = r_quo[ch];
            end
        end
    end

    always_comb begin
        o_result.red_out   = lane_out[mga_pkg::CH_RED];
        o_result.green_out = lane_out[mga_pkg::CH_GREEN];
        o_result.blue_out  = lane_out[mga_pkg::CH_BLUE];
        o_result.no_weight = r_no_wt;
        o_result.clipped   = !r_no_wt && (|r_clip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mga_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A quotient overflows eight bits exactly when the upper sum byte reaches the count,
    // so only the low byte of the dividend needs iterating.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bit   <= '0;
            r_count <= i_req.count;
            r_no_wt <= (i_req.count == '0);
            for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
                r_clip[ch] <= (i_req.sum[ch][mga_pkg::SUM_W-1:mga_pkg::CH_W] >= i_req.count);
                r_rem[ch]  <= i_req.sum[ch][mga_pkg::SUM_W-1:mga_pkg::CH_W];
                r_quo[ch]  <= i_req.sum[ch][mga_pkg::CH_W-1:0];
            end
        end else if (r_state == mga_pkg::DIV_RUN) begin
            r_bit <= r_bit + 1'b1;
            for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
                r_rem[ch] <= fits[ch] ? diff[ch][mga_pkg::CNT_W-1:0]
                                      : trial[ch][mga_pkg::CNT_W-1:0];
                r_quo[ch] <= {r_quo[ch][mga_pkg::CH_W-2:0], fits[ch]};
            end
        end
    end

endmodule

>>> rtl/core/mga_back.sv
// Back end: drains the pixel queue into the weighted sums and the weight count,
// and hands each finished window to the divider. Depends on mga_pkg, mga_div.

module mga_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mga_pkg::t_pix_entry i_entry,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output mga_pkg::t_result    o_result
);

    logic [mga_pkg::SUM_W-1:0] r_sum [mga_pkg::NUM_CH];
    logic [mga_pkg::SUM_W-1:0] n_sum [mga_pkg::NUM_CH];
    logic [mga_pkg::CH_W-1:0]  pix   [mga_pkg::NUM_CH];
    logic [mga_pkg::CNT_W-1:0] r_count;
    logic [mga_pkg::CNT_W-1:0] n_count;
    logic                      div_idle;
    logic                      start;
    mga_pkg::t_div_req         req;

    assign pix[mga_pkg::CH_RED]   = i_entry.red;
    assign pix[mga_pkg::CH_GREEN] = i_entry.green;
    assign pix[mga_pkg::CH_BLUE]  = i_entry.blue;

    // The closing pixel of a window waits until the divider is free.
    assign o_pop = !i_empty && (!i_entry.last || div_idle);
    assign start = o_pop && i_entry.last;

    always_comb begin
        for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
            n_sum[ch] = r_sum[ch]
                      + mga_pkg::SUM_W'(pix[ch]) * mga_pkg::SUM_W'(i_entry.weight);
            req.sum[ch] = n_sum[ch];
        end
        n_count   = i_entry.count_en ? r_count + mga_pkg::CNT_W'(i_entry.weight) : r_count;
        req.count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
                r_sum[ch] <= '0;
            end
        end else if (o_pop) begin
            r_count <= i_entry.last ? '0 : n_count;
            for (int ch = 0; ch < mga_pkg::NUM_CH; ch++) begin
                r_sum[ch] <= i_entry.last ? '0 : n_sum[ch];
            end
        end
    end

    mga_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (req),
        .o_idle   (div_idle),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

>>> rtl/core/masked_gaussian_rgb_average.sv
// Top level of the masked Gaussian RGB average block.
// Depends on mga_pkg, mga_pix_if, mga_res_if, mga_front, mga_fifo and mga_back.

// Pixels arrive on i_pix in windows of nine, row-major, and each transfer on o_res carries
// one window's three averaged channels with the no_weight and clipped flags. The front end
// takes one pixel per cycle while its four-entry queue has room, and the back end adds one
// queued pixel per cycle into the sums while the queue is not empty. At the end of a window
// the three channels are divided in parallel, one quotient bit per cycle: the divider
// loads, runs one iteration for each of the eight quotient bits and holds the result, or
// goes straight from load to result when the weight count is zero. This overlaps the next
// window, whose closing pixel waits for the divider. The result stays on o_res until it
// is taken, and a new i_cfg_data word on i_cfg_we replaces the mask for the pixels
// that follow.

module masked_gaussian_rgb_average (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [mga_pkg::MASK_W-1:0] i_cfg_data,
    mga_pix_if.sink                    i_pix,
    mga_res_if.source                  o_res
);

    mga_pkg::t_pix_entry push_entry;
    mga_pkg::t_pix_entry pop_entry;
    mga_pkg::t_result    result;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;

    mga_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_entry  (push_entry)
    );

    mga_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (pop_entry),
        .o_empty (q_empty)
    );

    mga_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (pop_entry),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (result)
    );

    assign o_res.red_out   = result.red_out;
    assign o_res.green_out = result.green_out;
    assign o_res.blue_out  = result.blue_out;
    assign o_res.no_weight = result.no_weight;
    assign o_res.clipped   = result.clipped;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for masked_gaussian_rgb_average: directed windows, then random pixels.
// Depends on mga_pkg, mga_pix_if, mga_res_if and the block itself.

module tb;

    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_OFF       = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 9;
    localparam int DIR_ROWS       = 27;

    typedef struct packed {
        logic [mga_pkg::CH_W-1:0] red;
        logic [mga_pkg::CH_W-1:0] green;
        logic [mga_pkg::CH_W-1:0] blue;
        logic                     typed;
        mga_pkg::t_result         res;
    } t_stim_row;

    localparam mga_pkg::t_result RES_NONE  = '0;
    localparam mga_pkg::t_result RES_FULL  = '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0};
    localparam mga_pkg::t_result RES_EMPTY = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
    localparam mga_pkg::t_result RES_CLIP  = '{8'd255, 8'd1, 8'd255, 1'b0, 1'b1};

    // Three windows under the reset mask: saturated white, all black (no weight),
    // and one where only the center pixel counts so red and blue overflow.
    localparam t_stim_row STIM_TABLE [DIR_ROWS] = '{
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd255, 8'd255, 1'b1, RES_FULL},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b0, RES_NONE},
        '{8'd0,   8'd0,   8'd0,   1'b1, RES_EMPTY},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd1,   8'd1,   8'd1,   1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b0, RES_NONE},
        '{8'd255, 8'd0,   8'd255, 1'b1, RES_CLIP}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       cfg_we;
    logic [mga_pkg::MASK_W-1:0] cfg_data;
    logic                       drv_typed;
    mga_pkg::t_result           drv_typed_res;

    mga_pix_if pix_if ();
    mga_res_if res_if ();

    masked_gaussian_rgb_average u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state of the window accumulator.
    logic [mga_pkg::MASK_W-1:0] mask_model = mga_pkg::RESET_MASK;
    int                         win_pos    = 0;
    logic [mga_pkg::SUM_W-1:0]  sum_red    = '0;
    logic [mga_pkg::SUM_W-1:0]  sum_green  = '0;
    logic [mga_pkg::SUM_W-1:0]  sum_blue   = '0;
    logic [mga_pkg::CNT_W-1:0]  weight_cnt = '0;
    mga_pkg::t_result           window_results_q [$];

    int  fail_count      = 0;
    int  idle_cycles     = 0;
    int  pixels_in       = 0;
    int  windows_out     = 0;
    int  mask_writes     = 0;
    int  empty_windows   = 0;
    int  clipped_windows = 0;
    bit  burst_mode      = 1'b0;
    bit  hold_off_req    = 1'b0;

    task automatic blur_absorb_pixel(input logic [mga_pkg::CH_W-1:0] r,
                                     input logic [mga_pkg::CH_W-1:0] g,
                                     input logic [mga_pkg::CH_W-1:0] b, input logic typed,
                                     input mga_pkg::t_result typed_res);
        logic [mga_pkg::W_W-1:0] w;
        mga_pkg::t_result        res;
        int                      quot [mga_pkg::NUM_CH];
        int                      sums [mga_pkg::NUM_CH];
        w = mask_model[win_pos*mga_pkg::W_W +: mga_pkg::W_W];
        if (r != 0 && g != 0 && b != 0) begin
            weight_cnt = weight_cnt + w;
        end
        sum_red   = sum_red + r * w;
        sum_green = sum_green + g * w;
        sum_blue  = sum_blue + b * w;
        if (win_pos < mga_pkg::WINDOW_PIXELS - 1) begin
            win_pos++;
        end else begin
            res = '0;
            if (weight_cnt == 0) begin
                res.no_weight = 1'b1;
            end else begin
                sums = '{int'(sum_red), int'(sum_green), int'(sum_blue)};
                for (int i = 0; i < mga_pkg::NUM_CH; i++) begin
                    quot[i] = sums[i] / int'(weight_cnt);
                    if (quot[i] > 255) begin
                        quot[i] = 255;
                        res.clipped = 1'b1;
                    end
                end
                res.red_out   = mga_pkg::CH_W'(quot[mga_pkg::CH_RED]);
                res.green_out = mga_pkg::CH_W'(quot[mga_pkg::CH_GREEN]);
                res.blue_out  = mga_pkg::CH_W'(quot[mga_pkg::CH_BLUE]);
            end
            window_results_q.push_back(typed ? typed_res : res);
            win_pos    = 0;
            sum_red    = '0;
            sum_green  = '0;
            sum_blue   = '0;
            weight_cnt = '0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // Everything is sampled here on the edge, before the drivers' updates land.
    always @(posedge i_clk) begin
        mga_pkg::t_result want;
        logic             moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (cfg_we) begin
                mask_model = cfg_data;
                mask_writes++;
                moved = 1'b1;
            end
            if (pix_if.valid && pix_if.ready) begin
                blur_absorb_pixel(pix_if.red, pix_if.green, pix_if.blue, drv_typed,
                                  drv_typed_res);
                pixels_in++;
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                windows_out++;
                if (res_if.no_weight) empty_windows++;
                if (res_if.clipped) clipped_windows++;
                if (window_results_q.size() == 0) begin
                    fail_count++;
                    $error("result transfer with no window expected");
                end else begin
                    want = window_results_q.pop_front();
                    check_field("red_out", want.red_out, res_if.red_out);
                    check_field("green_out", want.green_out, res_if.green_out);
                    check_field("blue_out", want.blue_out, res_if.blue_out);
                    check_field("no_weight", want.no_weight, res_if.no_weight);
                    check_field("clipped", want.clipped, res_if.clipped);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Result side: a random stall before each transfer outside burst mode, one long hold-off on request.
    initial begin
        int n;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            n = burst_mode ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                res_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
        end
    end

    task automatic offer_pixel(input logic [mga_pkg::CH_W-1:0] r,
                               input logic [mga_pkg::CH_W-1:0] g,
                               input logic [mga_pkg::CH_W-1:0] b, input logic typed,
                               input mga_pkg::t_result typed_res);
        int n;
        n = burst_mode ? 0 : $urandom_range(0, 17);
        if (n > 0) begin
            pix_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        pix_if.valid  <= 1'b1;
        pix_if.red    <= r;
        pix_if.green  <= g;
        pix_if.blue   <= b;
        drv_typed     <= typed;
        drv_typed_res <= typed_res;
        do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
    endtask

    // Waits until every pending window has come out and the pixel queue has drained.
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (window_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_mask(input logic [mga_pkg::MASK_W-1:0] m);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [mga_pkg::CH_W-1:0] rand_channel(input int mode);
        if (mode == 1) begin
            return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        end
        return mga_pkg::CH_W'($urandom_range(1, 255));
    endfunction

    initial begin
        logic [mga_pkg::MASK_W-1:0] m;
        logic [mga_pkg::CH_W-1:0]   ch [mga_pkg::NUM_CH];
        int                         mode;
        int                         items;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= mga_pkg::RESET_MASK;
        pix_if.valid  <= 1'b0;
        pix_if.red    <= '0;
        pix_if.green  <= '0;
        pix_if.blue   <= '0;
        drv_typed     <= 1'b0;
        drv_typed_res <= RES_NONE;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (STIM_TABLE[i]) begin
            offer_pixel(STIM_TABLE[i].red, STIM_TABLE[i].green, STIM_TABLE[i].blue,
                        STIM_TABLE[i].typed, STIM_TABLE[i].res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Each new mask lands wherever the previous phase left the window.
            m = mga_pkg::MASK_W'({$urandom, $urandom});
            case (ph)
                0: m = mga_pkg::RESET_MASK;
                1: m = '0;
                2: m = '1;
                3: m = mga_pkg::RESET_MASK;
                5: m = {mga_pkg::NUM_CH*mga_pkg::NUM_CH{4'h8}};
                default: begin
                    for (int k = 0; k < mga_pkg::WINDOW_PIXELS; k++) begin
                        if ($urandom_range(0, 2) == 0) m[k*mga_pkg::W_W +: mga_pkg::W_W] = '0;
                    end
                end
            endcase
            load_mask(m);
            burst_mode   = (ph % 4 == 2);
            hold_off_req = (ph == 3);
            items = $urandom_range(90, 120);
            for (int i = 0; i < items; i++) begin
                mode = $urandom_range(0, 99);
                for (int c = 0; c < mga_pkg::NUM_CH; c++) begin
                    ch[c] = rand_channel(mode < 6 ? 1 : 0);
                end
                if (mode >= 6 && mode < 16) begin
                    ch[$urandom_range(0, mga_pkg::NUM_CH-1)] = '0;
                end
                offer_pixel(ch[mga_pkg::CH_RED], ch[mga_pkg::CH_GREEN], ch[mga_pkg::CH_BLUE],
                            1'b0, RES_NONE);
            end
        end
        burst_mode = 1'b0;
        wait_idle();

        $display("%0d pixels sent, %0d windows checked over %0d mask settings",
                 pixels_in, windows_out, mask_writes + 1);
        $display("%0d windows had no weight, %0d were clipped", empty_windows,
                 clipped_windows);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
